### rtl/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

  localparam int SLOTS_DEFAULT        = 16;
  localparam int PAYLOAD_BITS_DEFAULT = 32;

  localparam int CMD_BITS      = 2;
  localparam int STATUS_BITS   = 2;
  localparam int HANDLE_BITS   = 31;
  localparam int DATA_BITS     = 32;
  localparam int SLOT_OUT_BITS = 4;
  localparam int GEN_BITS      = 8;
  localparam int FIELD_BITS    = 23;
  localparam int GEN_SHIFT     = 23;

  localparam logic [CMD_BITS-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic accept;
    logic pop;
    logic exec;
  } ght_ctl_t;

  typedef struct packed {
    logic stack_nonempty;
  } ght_sts_t;

endpackage

### rtl/ght_ctrl.sv
`timescale 1ns / 1ps

module ght_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ght_pkg::CMD_BITS-1:0] in_cmd,
  input  ght_pkg::ght_sts_t          sts,
  output logic                       busy,
  output ght_pkg::ght_ctl_t          ctl
);
  import ght_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    busy       = (state_r != S_IDLE);
    ctl.accept = start && (state_r == S_IDLE);
    ctl.pop    = (state_r == S_POP);
    ctl.exec   = (state_r == S_EXEC);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if ((in_cmd == CMD_ALLOC) && sts.stack_nonempty) begin
            state_nxt = S_POP;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_POP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/ght_dp.sv
`timescale 1ns / 1ps

module ght_dp #(
  parameter int SLOTS        = ght_pkg::SLOTS_DEFAULT,
  parameter int PAYLOAD_BITS = ght_pkg::PAYLOAD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ght_pkg::ght_ctl_t               ctl,
  output ght_pkg::ght_sts_t               sts,
  input  logic [ght_pkg::CMD_BITS-1:0]    in_cmd,
  input  logic [ght_pkg::HANDLE_BITS-1:0] in_handle_in,
  input  logic [ght_pkg::DATA_BITS-1:0]   in_payload_in,
  output logic                            out_valid,
  output logic [ght_pkg::STATUS_BITS-1:0] out_status,
  output logic [ght_pkg::HANDLE_BITS-1:0] out_handle_out,
  output logic [ght_pkg::DATA_BITS-1:0]   out_payload_out,
  output logic [ght_pkg::SLOT_OUT_BITS-1:0] out_slot_out
);
  import ght_pkg::*;

  localparam int SW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int PW  = (PAYLOAD_BITS < DATA_BITS) ? PAYLOAD_BITS : DATA_BITS;
  localparam int MW  = GEN_BITS + 1;
  localparam int SXW = SW + SLOT_OUT_BITS;
  localparam int PXW = PW + DATA_BITS;

  logic [PW-1:0] pay_mem   [SLOTS];
  logic [MW-1:0] meta_mem  [SLOTS];
  logic [SW-1:0] stack_mem [SLOTS];

  logic [CMD_BITS-1:0]    cmd_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [PW-1:0]          payload_r;
  logic                   from_stack_r;
  logic [CW-1:0]          depth_r, depth_nxt;
  logic [CW-1:0]          hw_r, hw_nxt;
  logic [SW-1:0]          stack_rd_r;
  logic [MW-1:0]          meta_rd_r;
  logic [PW-1:0]          pay_rd_r;

  logic                   out_valid_r;
  logic [STATUS_BITS-1:0] out_status_r, status_nxt;
  logic [HANDLE_BITS-1:0] out_handle_r, handle_nxt;
  logic [DATA_BITS-1:0]   out_payload_r, payload_nxt;
  logic [SLOT_OUT_BITS-1:0] out_slot_r;

  logic [FIELD_BITS-1:0]  in_field_m1;
  logic [CW-1:0]          depth_m1;
  logic [SW-1:0]          meta_raddr;
  logic [FIELD_BITS-1:0]  field_r;
  logic [FIELD_BITS-1:0]  field_m1_r;
  logic                   handle_ok;
  logic [SW-1:0]          alloc_idx;
  logic [GEN_BITS-1:0]    alloc_gen;
  logic                   table_full;
  logic [SW-1:0]          rel_idx;
  logic [SW-1:0]          slot_sel;
  logic [SXW-1:0]         slot_ext;
  logic [PXW-1:0]         pay_ext;

  logic                   pay_we;
  logic                   meta_we;
  logic [SW-1:0]          meta_waddr;
  logic [MW-1:0]          meta_wdata;
  logic                   stack_we;

  assign sts.stack_nonempty = (depth_r != '0);

  always_comb begin
    in_field_m1 = in_handle_in[FIELD_BITS-1:0] - FIELD_BITS'(1);
    depth_m1    = depth_r - CW'(1);
    meta_raddr  = ctl.pop ? stack_rd_r : in_field_m1[SW-1:0];
    field_r     = handle_r[FIELD_BITS-1:0];
    field_m1_r  = field_r - FIELD_BITS'(1);
    rel_idx     = field_m1_r[SW-1:0];
    handle_ok   = (field_r != '0) && (field_m1_r < FIELD_BITS'(hw_r)) &&
                  meta_rd_r[GEN_BITS] &&
                  (meta_rd_r[GEN_BITS-1:0] == handle_r[HANDLE_BITS-1:GEN_SHIFT]);
    alloc_idx   = from_stack_r ? stack_rd_r : hw_r[SW-1:0];
    alloc_gen   = from_stack_r ? meta_rd_r[GEN_BITS-1:0] : '0;
    table_full  = !from_stack_r && (hw_r == CW'(SLOTS));
    pay_ext     = PXW'(pay_rd_r);
  end

  always_comb begin
    pay_we      = 1'b0;
    meta_we     = 1'b0;
    stack_we    = 1'b0;
    meta_waddr  = alloc_idx;
    meta_wdata  = {1'b1, alloc_gen};
    depth_nxt   = depth_r;
    hw_nxt      = hw_r;
    status_nxt  = ST_INVALID;
    handle_nxt  = handle_r;
    payload_nxt = '0;
    slot_sel    = '0;
    case (cmd_r)
      CMD_ALLOC: begin
        if (table_full) begin
          status_nxt = ST_FULL;
          handle_nxt = '0;
        end else begin
          pay_we     = 1'b1;
          meta_we    = 1'b1;
          status_nxt = ST_OK;
          handle_nxt = {alloc_gen, FIELD_BITS'(alloc_idx) + FIELD_BITS'(1)};
          slot_sel   = alloc_idx;
          if (from_stack_r) begin
            depth_nxt = depth_r - CW'(1);
          end else begin
            hw_nxt = hw_r + CW'(1);
          end
        end
      end
      CMD_LOOKUP: begin
        if (handle_ok) begin
          status_nxt  = ST_OK;
          payload_nxt = pay_ext[DATA_BITS-1:0];
          slot_sel    = rel_idx;
        end
      end
      CMD_RELEASE: begin
        if (handle_ok) begin
          meta_we    = 1'b1;
          meta_waddr = rel_idx;
          meta_wdata = {1'b0, meta_rd_r[GEN_BITS-1:0] + GEN_BITS'(1)};
          status_nxt = ST_OK;
          slot_sel   = rel_idx;
          if (depth_r < CW'(SLOTS)) begin
            stack_we  = 1'b1;
            depth_nxt = depth_r + CW'(1);
          end
        end
      end
      default: begin
        status_nxt = ST_INVALID;
      end
    endcase
    slot_ext = SXW'(slot_sel);
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && pay_we) begin
      pay_mem[alloc_idx] <= payload_r;
    end
    if (ctl.exec && meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (ctl.exec && stack_we) begin
      stack_mem[depth_r[SW-1:0]] <= rel_idx;
    end
    if (ctl.accept) begin
      pay_rd_r   <= pay_mem[in_field_m1[SW-1:0]];
      stack_rd_r <= stack_mem[depth_m1[SW-1:0]];
    end
    if (ctl.accept || ctl.pop) begin
      meta_rd_r <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r        <= in_cmd;
      handle_r     <= in_handle_in;
      payload_r    <= in_payload_in[PW-1:0];
      from_stack_r <= (depth_r != '0);
    end
    if (ctl.exec) begin
      out_status_r  <= status_nxt;
      out_handle_r  <= handle_nxt;
      out_payload_r <= payload_nxt;
      out_slot_r    <= slot_ext[SLOT_OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.exec;
      if (ctl.exec) begin
        depth_r <= depth_nxt;
        hw_r    <= hw_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_handle_out  = out_handle_r;
  assign out_payload_out = out_payload_r;
  assign out_slot_out    = out_slot_r;

endmodule

### rtl/generational_handle_table.sv
`timescale 1ns / 1ps
// The result word is strobed after the controller's exec state; an allocate that reuses a
// released slot first passes a pop state that reads the metadata of the slot on the free stack top.
// A new command is taken only while idle, so each command completes before the next is accepted.
// Each result is shown for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the table; no clearing pass is needed.
module generational_handle_table #(
  parameter int SLOTS        = ght_pkg::SLOTS_DEFAULT,
  parameter int PAYLOAD_BITS = ght_pkg::PAYLOAD_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ght_pkg::CMD_BITS-1:0]      in_cmd,
  input  logic [ght_pkg::HANDLE_BITS-1:0]   in_handle_in,
  input  logic [ght_pkg::DATA_BITS-1:0]     in_payload_in,
  output logic                              out_valid,
  output logic [ght_pkg::STATUS_BITS-1:0]   out_status,
  output logic [ght_pkg::HANDLE_BITS-1:0]   out_handle_out,
  output logic [ght_pkg::DATA_BITS-1:0]     out_payload_out,
  output logic [ght_pkg::SLOT_OUT_BITS-1:0] out_slot_out
);
  import ght_pkg::*;

  ght_ctl_t ctl;
  ght_sts_t sts;

  ght_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .busy   (busy),
    .ctl    (ctl)
  );

  ght_dp #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_handle_in    (in_handle_in),
    .in_payload_in   (in_payload_in),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_handle_out  (out_handle_out),
    .out_payload_out (out_payload_out),
    .out_slot_out    (out_slot_out)
  );

`ifndef ASSERT_OFF
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result word strobed while a command is still in flight.");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Two result words strobed in consecutive cycles.");

  a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd != CMD_ALLOC)) |-> ##2 out_valid)
    else $error("Look-up or release result word did not arrive after two cycles.");
`endif

endmodule
